// ----- rtl/oahm_pkg.sv -----
// oahm_pkg: shared types, codes and constants for the open addressing hash map
// no dependencies
package oahm_pkg;

    localparam int TABLE_SIZE_DEF    = 256;
    localparam int PERTURB_SHIFT_DEF = 5;
    localparam int PROBE_EXTRA       = 40;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_UNHASHABLE = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2,
        TAG_SPARE = 2'd3
    } tag_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_READ,
        BK_CHECK,
        BK_COMMIT,
        BK_OUT
    } bk_state_t;

    // classified request between front and back
    typedef struct packed {
        logic [1:0]  action;
        logic        unhashable;
        logic [31:0] key;
        logic [31:0] hash_code;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [8:0]  live_entries;
    } rsp_t;

endpackage

// ----- rtl/oahm_front.sv -----
// oahm_front: accepts requests, checks the unhashable code, queues them for the back end
// depends on oahm_pkg
module oahm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic [31:0]        key,
    input  logic [31:0]        hash_code,
    input  logic [31:0]        value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    output logic               req_valid,
    input  logic               req_take,
    output oahm_pkg::req_t     req
);
    import oahm_pkg::*;

    logic [31:0] invalid_hash_reg;
    req_t        q_reg [2];
    logic [1:0]  cnt_reg;
    logic        wr_reg;
    logic        rd_reg;
    logic        do_push;
    logic        do_pop;
    req_t        incoming;

    assign cfg_ready = 1'b1;
    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign do_pop    = req_take && (cnt_reg != 2'd0);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_reg];

    always_comb
    begin
        incoming.action     = action;
        incoming.unhashable = (hash_code == invalid_hash_reg);
        incoming.key        = key;
        incoming.hash_code  = hash_code;
        incoming.value      = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_hash_reg <= '0;
            cnt_reg          <= '0;
            wr_reg           <= 1'b0;
            rd_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                invalid_hash_reg <= cfg_data;
            end
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= incoming;
        end
    end

endmodule

// ----- rtl/oahm_back.sv -----
// oahm_back: probes the slot memories and carries out lookup, insert and remove
// depends on oahm_pkg
module oahm_back #(
    parameter int TABLE_SIZE    = oahm_pkg::TABLE_SIZE_DEF,
    parameter int PERTURB_SHIFT = oahm_pkg::PERTURB_SHIFT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_take,
    input  oahm_pkg::req_t     req,
    output logic               rsp_valid,
    input  logic               rsp_take,
    output oahm_pkg::rsp_t     rsp
);
    import oahm_pkg::*;

    localparam int AW       = $clog2(TABLE_SIZE);
    localparam int CW       = $clog2(TABLE_SIZE + 1);
    localparam int PW       = $clog2(TABLE_SIZE + PROBE_EXTRA + 1);
    localparam int LIMIT    = TABLE_SIZE + PROBE_EXTRA;
    localparam int FILL_MAX = (TABLE_SIZE * 2) / 3;

    tag_t        tag_mem [TABLE_SIZE];
    logic [31:0] key_mem [TABLE_SIZE];
    logic [31:0] hash_mem [TABLE_SIZE];
    logic [31:0] val_mem [TABLE_SIZE];

    bk_state_t   state_reg, state_next;
    req_t        cur_reg;
    logic [31:0] i_reg, i_next;
    logic [31:0] pert_reg;
    logic [PW-1:0] n_reg;
    logic        have_tomb_reg;
    logic [AW-1:0] tomb_reg;
    logic [AW-1:0] clr_reg;
    logic [CW-1:0] filled_reg;
    logic [CW-1:0] used_reg;
    logic [AW-1:0] where_reg;
    logic [1:0]  hit_reg;
    logic [1:0]  status_reg;
    logic [31:0] found_reg;
    logic [31:0] hit_val_reg;
    tag_t        rd_tag;
    logic [31:0] rd_key, rd_hash, rd_val;
    logic [AW-1:0] idx;
    logic [AW-1:0] last_idx_reg;

    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_EMPTY = 2'd1;
    localparam logic [1:0] HIT_TOMB  = 2'd2;
    localparam logic [1:0] HIT_LIVE  = 2'd3;

    logic done_probe;
    logic [1:0] hit_now;
    logic [AW-1:0] where_now;

    assign idx    = AW'(i_reg);
    assign i_next = i_reg * 32'd5 + 32'd1 + pert_reg;
    assign req_take  = (state_reg == BK_IDLE) && req_valid;
    assign rsp_valid = (state_reg == BK_OUT);
    // live count after the commit
    assign rsp       = {status_reg, found_reg, 9'(used_reg)};

    always_ff @(posedge clk)
    begin
        rd_tag  <= tag_mem[idx];
        rd_key  <= key_mem[idx];
        rd_hash <= hash_mem[idx];
        rd_val  <= val_mem[idx];
    end

    // probe decision on the registered slot read
    always_comb
    begin
        done_probe = 1'b0;
        hit_now    = HIT_NONE;
        where_now  = last_idx_reg;
        if (rd_tag == TAG_EMPTY)
        begin
            done_probe = 1'b1;
            hit_now    = have_tomb_reg ? HIT_TOMB : HIT_EMPTY;
            where_now  = have_tomb_reg ? tomb_reg : last_idx_reg;
        end
        else if (rd_tag == TAG_LIVE && rd_hash == cur_reg.hash_code && rd_key == cur_reg.key)
        begin
            done_probe = 1'b1;
            hit_now    = HIT_LIVE;
        end
        else if (n_reg == PW'(LIMIT - 1))
        begin
            done_probe = 1'b1;
            if (have_tomb_reg || rd_tag == TAG_TOMB)
            begin
                hit_now   = HIT_TOMB;
                where_now = have_tomb_reg ? tomb_reg : last_idx_reg;
            end
            else
            begin
                hit_now   = HIT_NONE;
                where_now = '0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:  state_next = (clr_reg == AW'(TABLE_SIZE - 1)) ? BK_IDLE : BK_CLEAR;
            BK_IDLE:   if (req_valid)
                       begin
                           state_next = (req.unhashable || req.action == ACT_NONE)
                                        ? BK_COMMIT : BK_READ;
                       end
            BK_READ:   state_next = BK_CHECK;
            BK_CHECK:  state_next = done_probe ? BK_COMMIT : BK_READ;
            BK_COMMIT: state_next = BK_OUT;
            BK_OUT:    if (rsp_take) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_CLEAR;
            clr_reg    <= '0;
            filled_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == BK_COMMIT && !cur_reg.unhashable)
            begin
                if (cur_reg.action == ACT_REMOVE && hit_reg == HIT_LIVE)
                begin
                    used_reg <= used_reg - CW'(1);
                end
                else if (cur_reg.action == ACT_INSERT)
                begin
                    if (hit_reg == HIT_TOMB)
                    begin
                        used_reg <= used_reg + CW'(1);
                    end
                    else if (hit_reg == HIT_EMPTY && int'(filled_reg) < FILL_MAX)
                    begin
                        used_reg   <= used_reg + CW'(1);
                        filled_reg <= filled_reg + CW'(1);
                    end
                end
            end
        end
    end

    // memory writes: clearing pass and commit
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_CLEAR)
        begin
            tag_mem[clr_reg] <= TAG_EMPTY;
        end
        else if (state_reg == BK_COMMIT && !cur_reg.unhashable)
        begin
            if (cur_reg.action == ACT_REMOVE && hit_reg == HIT_LIVE)
            begin
                tag_mem[where_reg] <= TAG_TOMB;
            end
            else if (cur_reg.action == ACT_INSERT)
            begin
                if (hit_reg == HIT_LIVE)
                begin
                    val_mem[where_reg] <= cur_reg.value;
                end
                else if (hit_reg == HIT_TOMB ||
                         (hit_reg == HIT_EMPTY && int'(filled_reg) < FILL_MAX))
                begin
                    tag_mem[where_reg]  <= TAG_LIVE;
                    key_mem[where_reg]  <= cur_reg.key;
                    hash_mem[where_reg] <= cur_reg.hash_code;
                    val_mem[where_reg]  <= cur_reg.value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cur_reg       <= req;
                i_reg         <= req.hash_code;
                pert_reg      <= req.hash_code;
                n_reg         <= '0;
                have_tomb_reg <= 1'b0;
                tomb_reg      <= '0;
                hit_reg       <= HIT_NONE;
                where_reg     <= '0;
            end
            BK_READ:
            begin
                last_idx_reg <= idx;
                i_reg        <= i_next;
                pert_reg     <= pert_reg >> PERTURB_SHIFT;
            end
            BK_CHECK:
            begin
                n_reg <= n_reg + PW'(1);
                if (rd_tag == TAG_TOMB && !have_tomb_reg)
                begin
                    have_tomb_reg <= 1'b1;
                    tomb_reg      <= last_idx_reg;
                end
                hit_reg     <= hit_now;
                where_reg   <= where_now;
                hit_val_reg <= rd_val;
            end
            BK_COMMIT:
            begin
                found_reg  <= '0;
                status_reg <= ST_NOT_FOUND;
                if (cur_reg.unhashable)
                begin
                    status_reg <= ST_UNHASHABLE;
                end
                else if (cur_reg.action == ACT_LOOKUP)
                begin
                    if (hit_reg == HIT_LIVE)
                    begin
                        status_reg <= ST_OK;
                        found_reg  <= hit_val_reg;
                    end
                end
                else if (cur_reg.action == ACT_REMOVE)
                begin
                    if (hit_reg == HIT_LIVE)
                    begin
                        status_reg <= ST_OK;
                    end
                end
                else if (cur_reg.action == ACT_INSERT)
                begin
                    if (hit_reg == HIT_LIVE || hit_reg == HIT_TOMB ||
                        (hit_reg == HIT_EMPTY && int'(filled_reg) < FILL_MAX))
                    begin
                        status_reg <= ST_OK;
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/oahm_out.sv -----
// oahm_out: two-entry result queue toward the pop side
// depends on oahm_pkg
module oahm_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rsp_valid,
    output logic            rsp_take,
    input  oahm_pkg::rsp_t  rsp,
    output logic            empty,
    input  logic            pop,
    output logic [1:0]      status,
    output logic [31:0]     found_value,
    output logic [8:0]      live_entries
);
    import oahm_pkg::*;

    rsp_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       wr_reg, rd_reg;
    logic       do_pop;

    assign rsp_take     = rsp_valid && (cnt_reg != 2'd2);
    assign do_pop       = pop && (cnt_reg != 2'd0);
    assign empty        = (cnt_reg == 2'd0);
    assign status       = q_reg[rd_reg].status;
    assign found_value  = q_reg[rd_reg].found_value;
    assign live_entries = q_reg[rd_reg].live_entries;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            if (rsp_take) wr_reg <= !wr_reg;
            if (do_pop)   rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, rsp_take} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_take)
        begin
            q_reg[wr_reg] <= rsp;
        end
    end

endmodule

// ----- rtl/open_addressing_hash_map.sv -----
// open_addressing_hash_map: top level, front queue, probing back end, result queue
// depends on oahm_pkg, oahm_front, oahm_back, oahm_out
//
// channel   direction  handshake             payload
// request   in         push / full           action, key, hash_code, value
// config    in         cfg_valid / cfg_ready cfg_data (invalid hash code)
// result    out        empty / pop           status, found_value, live_entries
//
// a request probes slot by slot, a memory read state then a check state per slot, then commits and outputs
// unhashable requests and ACT_NONE skip the probe and go straight to commit
// after reset a clearing pass over every slot empties the tag memory
// full and empty stall each side independently through two-entry queues
module open_addressing_hash_map #(
    parameter int TABLE_SIZE    = oahm_pkg::TABLE_SIZE_DEF,
    parameter int PERTURB_SHIFT = oahm_pkg::PERTURB_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [31:0] key,
    input  logic [31:0] hash_code,
    input  logic [31:0] value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [31:0] found_value,
    output logic [8:0]  live_entries
);
    import oahm_pkg::*;

    logic req_valid, req_take, rsp_valid, rsp_take;
    req_t req;
    rsp_t rsp;

    oahm_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .action(action), .key(key), .hash_code(hash_code), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_take(req_take), .req(req)
    );

    oahm_back #(
        .TABLE_SIZE(TABLE_SIZE),
        .PERTURB_SHIFT(PERTURB_SHIFT)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_take(req_take), .req(req),
        .rsp_valid(rsp_valid), .rsp_take(rsp_take), .rsp(rsp)
    );

    oahm_out u_out (
        .clk(clk), .rst_n(rst_n),
        .rsp_valid(rsp_valid), .rsp_take(rsp_take), .rsp(rsp),
        .empty(empty), .pop(pop),
        .status(status), .found_value(found_value), .live_entries(live_entries)
    );

endmodule

// ----- rtl/oahm_checker.sv -----
// oahm_checker: port-level assertions for the hash map, bound to the top level
// depends on open_addressing_hash_map ports only
module oahm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  status,
    input logic [31:0] found_value,
    input logic [8:0]  live_entries
);
    // found value only on a good lookup or other ok
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != 2'd0) |-> found_value == 32'd0)
        else $error("found_value nonzero on failed item");

    // live count never exceeds two thirds of the table
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> live_entries <= 9'd170)
        else $error("live_entries beyond fill limit");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(live_entries)))
        else $error("result changed while waiting");

    // handshake signals stay known out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({push, full, empty, pop}))
        else $error("handshake signal unknown");

endmodule

bind open_addressing_hash_map oahm_checker u_oahm_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
    .status(status), .found_value(found_value), .live_entries(live_entries)
);

// ----- test/tb_open_addressing_hash_map.sv -----
// tb_open_addressing_hash_map: self-checking testbench for the open addressing hash map
// depends on oahm_pkg and open_addressing_hash_map
`timescale 1ns / 1ps

module tb_open_addressing_hash_map;
    import oahm_pkg::*;

    localparam int TSIZE      = 256;
    localparam int PSHIFT     = 5;
    localparam int PLIMIT     = TSIZE + 40;
    localparam int IDLE_LIMIT = 20000;
    localparam int CFG_IDX_HASH = 0;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [8:0]  live_entries;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] hash_code;
    logic [31:0] value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        empty;
    logic        pop;
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [8:0]  live_entries;

    // predictor state
    tag_t        m_tag [TSIZE];
    logic [31:0] m_key [TSIZE];
    logic [31:0] m_val [TSIZE];
    logic [31:0] m_hash [TSIZE];
    int          m_filled;
    int          m_used;
    logic [31:0] m_bad_hash;

    answer_t     answer_q [$];
    int          errors;
    int          idle_cycles;
    int          sent;
    int          got;
    bit          no_idle;
    int          hold_off;
    logic [31:0] known_keys [$];

    open_addressing_hash_map i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .key          (key),
        .hash_code    (hash_code),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .found_value  (found_value),
        .live_entries (live_entries)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic answer_t predict_answer(logic [1:0] act, logic [31:0] k,
                                               logic [31:0] h, logic [31:0] v);
        answer_t     r;
        logic [31:0] i;
        logic [31:0] pert;
        logic [31:0] idx;
        logic [31:0] tomb;
        logic [31:0] where;
        bit          have_tomb;
        int          kind;
        r = '0;
        r.status = ST_NOT_FOUND;
        i = h;
        pert = h;
        have_tomb = 0;
        tomb = 0;
        where = 0;
        kind = 0;
        if (h == m_bad_hash)
        begin
            r.status = ST_UNHASHABLE;
        end
        else if (act != ACT_NONE)
        begin
            for (int n = 0; n < PLIMIT && kind == 0; n++)
            begin
                idx = (i & (TSIZE - 1)) % TSIZE;
                if (m_tag[idx] == TAG_EMPTY)
                begin
                    kind = have_tomb ? 2 : 1;
                    where = have_tomb ? tomb : idx;
                end
                else if (m_tag[idx] == TAG_TOMB)
                begin
                    if (!have_tomb)
                    begin
                        have_tomb = 1;
                        tomb = idx;
                    end
                end
                else if (m_hash[idx] == h && m_key[idx] == k)
                begin
                    kind = 3;
                    where = idx;
                end
                i = i * 5 + 1 + pert;
                pert = pert >> PSHIFT;
            end
            if (kind == 0 && have_tomb)
            begin
                kind = 2;
                where = tomb;
            end
            if (act == ACT_LOOKUP)
            begin
                if (kind == 3)
                begin
                    r.status = ST_OK;
                    r.found_value = m_val[where];
                end
            end
            else if (act == ACT_REMOVE)
            begin
                if (kind == 3)
                begin
                    m_tag[where] = TAG_TOMB;
                    m_used--;
                    r.status = ST_OK;
                end
            end
            else if (kind == 3)
            begin
                m_val[where] = v;
                r.status = ST_OK;
            end
            else if (kind == 2 || (kind == 1 && (m_filled + 1) * 3 <= TSIZE * 2))
            begin
                m_tag[where] = TAG_LIVE;
                m_key[where] = k;
                m_hash[where] = h;
                m_val[where] = v;
                if (kind == 1)
                    m_filled++;
                m_used++;
                r.status = ST_OK;
            end
            else
            begin
                r.status = ST_FULL;
            end
        end
        r.live_entries = m_used[8:0];
        return r;
    endfunction

    task automatic random_gap();
        int n;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_request(logic [1:0] act, logic [31:0] k, logic [31:0] h,
                                logic [31:0] v);
        random_gap();
        @(negedge clk);
        push = 1'b1;
        action = act;
        key = k;
        hash_code = h;
        value = v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        answer_q.push_back(predict_answer(act, k, h, v));
        sent++;
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic wait_drained();
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_bad_hash(logic [31:0] d);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        m_bad_hash = d;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // result checker with random pop stalls
    initial
    begin
        int n;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                pop = 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                pop = 1'b0;
                n = $urandom_range(1, 16);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && pop && !empty)
        begin
            got++;
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected item status=%0d value=%h live=%0d",
                         $time, status, found_value, live_entries);
                errors++;
            end
            else
            begin
                e = answer_q.pop_front();
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                    errors++;
                end
                if (found_value !== e.found_value)
                begin
                    $display("%0t: found_value expected %h actual %h", $time,
                             e.found_value, found_value);
                    errors++;
                end
                if (live_entries !== e.live_entries)
                begin
                    $display("%0t: live_entries expected %0d actual %0d", $time,
                             e.live_entries, live_entries);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_request(ACT_LOOKUP, 32'h1, 32'h5, 32'h0);
        send_request(ACT_INSERT, 32'h0, 32'h1, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_INSERT, 32'h0, 32'h1, 32'hA5A5_A5A5);
        send_request(ACT_LOOKUP, 32'h0, 32'h1, 32'h0);
        // same hash, different key collides
        send_request(ACT_INSERT, 32'h7, 32'h1, 32'h7777_0000);
        send_request(ACT_LOOKUP, 32'h7, 32'h1, 32'hFFFF_FFFF);
        send_request(ACT_REMOVE, 32'h0, 32'h1, 32'h0);
        send_request(ACT_LOOKUP, 32'h0, 32'h1, 32'h0);
        send_request(ACT_LOOKUP, 32'h7, 32'h1, 32'h0);
        send_request(ACT_REMOVE, 32'h0, 32'h1, 32'h0);
        send_request(ACT_INSERT, 32'h9, 32'h101, 32'h9);
        send_request(ACT_NONE, 32'h7, 32'h1, 32'h1);
        send_request(ACT_INSERT, 32'h5, 32'h0, 32'h5);
        send_request(ACT_LOOKUP, 32'h5, 32'h0, 32'h5);
        send_request(ACT_REMOVE, 32'h5, 32'h0, 32'h5);
    endtask

    task automatic test_random(int count, int key_span);
        logic [31:0] k;
        logic [1:0]  a;
        for (int n = 0; n < count; n++)
        begin
            if (known_keys.size() != 0 && $urandom_range(0, 2) != 0)
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else
            begin
                k = ($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, key_span);
                known_keys.push_back(k);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: a = ACT_INSERT;
                4, 5, 6:    a = ACT_LOOKUP;
                7, 8:       a = ACT_REMOVE;
                default:    a = ACT_NONE;
            endcase
            // hash derived from key so equal keys share a hash, with rare noise
            send_request(a, k, ($urandom_range(0, 19) == 0) ? rand_word() : k * 32'h9E37_79B1,
                         rand_word());
        end
    endtask

    task automatic test_fill_and_stall();
        hold_off = 600;
        for (int n = 0; n < 190; n++)
            send_request(ACT_INSERT, 32'h8000_0000 + n, (32'h8000_0000 + n) * 32'h2545_F491,
                         $urandom());
    endtask

    task automatic test_bad_hash();
        write_bad_hash(32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'h3, 32'hFFFF_FFFF, 32'h3);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_INSERT, 32'h3, 32'h0, 32'h3);
        write_bad_hash($urandom());
        send_request(ACT_LOOKUP, 32'h3, m_bad_hash, 32'h0);
        write_bad_hash(32'h0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        action = ACT_LOOKUP;
        key = '0;
        hash_code = '0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        sent = 0;
        got = 0;
        no_idle = 0;
        hold_off = 0;
        m_bad_hash = '0;
        m_filled = 0;
        m_used = 0;
        foreach (m_tag[j])
        begin
            m_tag[j] = TAG_EMPTY;
            m_key[j] = '0;
            m_val[j] = '0;
            m_hash[j] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_bad_hash();
        test_random(200, 63);
        test_bad_hash();
        test_fill_and_stall();
        no_idle = 1;
        test_random(60, 1023);

        wait_drained();
        $display("sent %0d requests, checked %0d results, table reached %0d of %0d slots",
                 sent, got, m_filled, TSIZE);
        if (errors == 0 && answer_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
